/* sv/bounded_random_index_generator_core_defines.svh */
// ---------------------------------------------------------------------------
// Bounded random index generator: assertion macros
// Shared assertion wrappers for the checker that watches the core's ports.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_RANDOM_INDEX_GENERATOR_CORE_DEFINES_SVH
`define BOUNDED_RANDOM_INDEX_GENERATOR_CORE_DEFINES_SVH

// Clocked assertion, masked while reset is asserted
`define BRIG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset
`define BRIG_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/brig_pkg.sv */
// ---------------------------------------------------------------------------
// brig_pkg
// Types and constants shared by the controller and datapath of the bounded
// random index generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brig_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    // xorshift64* output multiplier, split into halves
    localparam logic [HALF_W-1:0] STAR_MUL_LO = 32'h4F6C_DD1D;
    localparam logic [HALF_W-1:0] STAR_MUL_HI = 32'h2545_F491;

    // splitmix64 mix of zero, used in place of a zero generator state
    localparam logic [WORD_W-1:0] DEFAULT_STATE = 64'hE220_A839_7B1D_CDAF;

    typedef logic [WORD_W-1:0] t_word;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_REM_DIV,
        S_REM_FIX,
        S_DRAW,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_CHECK,
        S_MOD_DIV,
        S_OUT
    } t_state;

    // Partial-product select for the shared 32x32 multiplier
    typedef enum logic [1:0] {
        MUL_LL,
        MUL_HL,
        MUL_LH
    } t_mul_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load_bound;
        logic     div_init_ones;
        logic     div_init_x;
        logic     div_step;
        logic     rem_fix;
        logic     draw;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bound_zero;
        logic x_ok;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* sv/brig_dp.sv */
// ---------------------------------------------------------------------------
// brig_dp
// Datapath: generator state, shared multiplier, restoring divider,
// rejection threshold and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brig_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  brig_pkg::t_cmd        i_cmd,
    output brig_pkg::t_sts        o_sts,
    input  logic                  i_cfg_wr_en,
    input  logic [63:0]           i_cfg_wr_data,
    input  logic [63:0]           i_bound,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [63:0]           o_out_value,
    output logic                  o_out_bad
);
    import brig_pkg::*;

    t_word               r_bound;
    logic                r_bad;
    t_word               r_state;
    t_word               r_div_rem;
    t_word               r_div_q;
    t_word               r_rej_rem;
    t_word               r_limit;
    t_word               r_prod;
    t_word               r_x;
    logic                r_out_valid;
    t_word               r_out_value;
    logic                r_out_bad;

    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     diff;
    t_word               rem_inc;
    t_word               s0, s1, s2, s3;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;

    // Bound and zero-bound flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bound) begin
            r_bound <= i_bound;
            r_bad   <= (i_bound == '0);
        end
    end

    // One restoring divider step: shift in next dividend bit, trial subtract
    assign trial   = {r_div_rem, r_div_q[WORD_W-1]};
    assign diff    = trial - {1'b0, r_bound};
    assign rem_inc = r_div_rem + t_word'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init_ones) begin
            r_div_rem <= '0;
            r_div_q   <= '1;
        end else if (i_cmd.div_init_x) begin
            r_div_rem <= '0;
            r_div_q   <= r_x;
        end else if (i_cmd.div_step) begin
            r_div_rem <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            r_div_q   <= r_div_q << 1;
        end
    end

    // 2^64 mod n = ((2^64-1) mod n + 1) mod n
    always_ff @(posedge i_clk) begin
        if (i_cmd.rem_fix) begin
            r_rej_rem <= (rem_inc == r_bound) ? '0 : rem_inc;
        end
        r_limit <= '0 - r_rej_rem;
    end

    // xorshift state update
    always_comb begin
        s0 = (r_state == '0) ? DEFAULT_STATE : r_state;
        s1 = s0 ^ (s0 >> 12);
        s2 = s1 ^ (s1 << 25);
        s3 = s2 ^ (s2 >> 27);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_cfg_wr_en) begin
            r_state <= i_cfg_wr_data;
        end else if (i_cmd.draw) begin
            r_state <= s3;
        end
    end

    // Shared 32x32 multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LL: begin
                mul_a = r_state[HALF_W-1:0];
                mul_b = STAR_MUL_LO;
            end
            MUL_HL: begin
                mul_a = r_state[WORD_W-1:HALF_W];
                mul_b = STAR_MUL_LO;
            end
            MUL_LH: begin
                mul_a = r_state[HALF_W-1:0];
                mul_b = STAR_MUL_HI;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product register, then low 64 bits accumulated from partial products
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
        end
        if (i_cmd.acc_load) begin
            r_x <= r_prod;
        end else if (i_cmd.acc_add) begin
            r_x[WORD_W-1:HALF_W] <= r_x[WORD_W-1:HALF_W] + r_prod[HALF_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= r_bad ? '0 : r_div_rem;
            r_out_bad   <= r_bad;
        end
    end

    assign o_sts.bound_zero = r_bad;
    assign o_sts.x_ok       = (r_rej_rem == '0) || (r_x < r_limit);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_bad   = r_out_bad;

endmodule

`default_nettype wire

/* sv/brig_ctrl.sv */
// ---------------------------------------------------------------------------
// brig_ctrl
// Controller: sequences remainder computation, draws, rejection test,
// final modulo and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brig_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  brig_pkg::t_sts i_sts,
    output brig_pkg::t_cmd o_cmd
);
    import brig_pkg::*;

    t_state       r_state;
    t_state       n_state;
    logic [5:0]   r_cnt;
    logic [5:0]   n_cnt;
    logic         cnt_last;

    assign cnt_last = (r_cnt == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_LL;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_bound = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.bound_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_init_ones = 1'b1;
                    n_cnt   = '0;
                    n_state = S_REM_DIV;
                end
            end
            S_REM_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (cnt_last) begin
                    n_state = S_REM_FIX;
                end
            end
            S_REM_FIX: begin
                o_cmd.rem_fix = 1'b1;
                n_state = S_DRAW;
            end
            S_DRAW: begin
                o_cmd.draw = 1'b1;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LL;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_HL;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LH;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.acc_add = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // rejected draws go round again
                if (i_sts.x_ok) begin
                    o_cmd.div_init_x = 1'b1;
                    n_cnt   = '0;
                    n_state = S_MOD_DIV;
                end else begin
                    n_state = S_DRAW;
                end
            end
            S_MOD_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (cnt_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/bounded_random_index_generator_core.sv */
// ---------------------------------------------------------------------------
// bounded_random_index_generator_core
// Returns a uniform value below a requested bound from an xorshift64*
// generator, using rejection sampling to remove modulo bias.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (i_s_axis_*): one beat carries a 64-bit bound.
//   Output stream (o_m_axis_*): one beat per input beat; tdata holds the
//   value, tuser the bad_bound flag (set, value zero, for a zero bound).
//   Seed: pulse i_cfg_wr_en with i_cfg_wr_data while the core is idle to
//   load the generator state; zero selects the built-in default state.
// Operation:
//   Zero bound: the beat goes straight from S_START to S_OUT.
//   Otherwise the one-bit-per-cycle divider runs twice (64 steps each: once
//   for 2^64 mod n, once for the final modulo), around a 64-bit multiply
//   split into 32x32 partial products; each rejected draw (usually none)
//   repeats the draw, multiply and check. One item in flight; the next
//   bound is taken the cycle after the result loads.
// Reset: synchronous, active low; clears the generator state to zero,
//   the controller to idle and the output valid.
// Stall: a result waits in the output register while tready is low; the
//   core accepts and computes the next item, holding it until the register
//   frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_random_index_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register write
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] bound
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] value
    output logic [0:0]  o_m_axis_tuser    // [0] bad_bound
);
    import brig_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic out_bad;

    brig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    brig_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_bound       (i_s_axis_tdata),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_value   (o_m_axis_tdata),
        .o_out_bad     (out_bad)
    );

    assign o_m_axis_tuser = out_bad;

endmodule

`default_nettype wire

/* sv/brig_checker.sv */
// ---------------------------------------------------------------------------
// brig_checker
// Port-level checks for the bounded random index generator core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_random_index_generator_core_defines.svh"

module brig_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [63:0] o_m_axis_tdata,
    input  logic [0:0]  o_m_axis_tuser
);

    // stalled result beat holds
    `BRIG_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "output beat changed while stalled")

    // zero-bound result carries a zero value
    `BRIG_ASSERT(a_bad_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 64'd0, "bad bound with nonzero value")

    // one item at a time: input closes right after a beat
    `BRIG_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "input accepted while busy")

    // no result shows the cycle after reset
    `BRIG_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind bounded_random_index_generator_core brig_checker u_brig_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
